[sv/sha3_224_fixed_message_defines.svh]
// Assertion macros for the checker file of this block.
`ifndef SHA3_224_FIXED_MESSAGE_DEFINES_SVH
`define SHA3_224_FIXED_MESSAGE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SHA3_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define SHA3_ASSERT_NEVER(label, cond, msg) \
	`SHA3_ASSERT(label, !(cond), msg)

`endif

[sv/sha3_224_pkg.sv]
`timescale 1ns / 1ps

package sha3_224_pkg;

	typedef logic [63:0] lane_t;
	typedef logic [24:0][63:0] state_t;

	typedef struct packed {
		lane_t       rc;
		logic [7:0]  lfsr;
	} round_const_t;

	localparam int unsigned LANES        = 25;
	localparam int unsigned ROUNDS       = 24;
	localparam int unsigned DIGEST_WORDS = 7;
	localparam int unsigned DIGEST_BITS  = 224;
	localparam int unsigned PAD_END_LANE = 17;
	localparam logic [7:0]  PAD_FIRST    = 8'h06;
	localparam logic [7:0]  PAD_LAST     = 8'h80;
	localparam logic [7:0]  LFSR_INIT    = 8'h01;
	localparam logic [7:0]  LFSR_POLY    = 8'h71;

	localparam logic [5:0] RHO [25] = '{
		6'd0,  6'd1,  6'd62, 6'd28, 6'd27,
		6'd36, 6'd44, 6'd6,  6'd55, 6'd20,
		6'd3,  6'd10, 6'd43, 6'd25, 6'd39,
		6'd41, 6'd45, 6'd15, 6'd21, 6'd8,
		6'd18, 6'd2,  6'd61, 6'd56, 6'd14
	};

	function automatic lane_t rotl(input lane_t v, input logic [5:0] r);
		lane_t res;
		res = (v << r) | (v >> (7'd64 - {1'b0, r}));
		return res;
	endfunction

	// Steps the round-constant LFSR seven times and collects the constant.
	function automatic round_const_t round_const(input logic [7:0] seed);
		round_const_t res;
		logic [7:0]   s;
		res.rc = '0;
		s = seed;
		for (int j = 0; j < 7; j++) begin
			if (s[0]) begin
				res.rc[(1 << j) - 1] = 1'b1;
			end
			s = s[7] ? ({s[6:0], 1'b0} ^ LFSR_POLY) : {s[6:0], 1'b0};
		end
		res.lfsr = s;
		return res;
	endfunction

endpackage

[sv/sha3_224_round.sv]
`timescale 1ns / 1ps

module sha3_224_round (
	input  sha3_224_pkg::state_t lanes,
	input  sha3_224_pkg::lane_t  rc,
	output sha3_224_pkg::state_t lanes_next
);
	import sha3_224_pkg::*;

	lane_t col [5];
	lane_t dlt [5];
	lane_t th  [25];
	lane_t pi  [25];

	always_comb begin
		for (int x = 0; x < 5; x++) begin
			col[x] = lanes[x] ^ lanes[x + 5] ^ lanes[x + 10] ^ lanes[x + 15] ^ lanes[x + 20];
		end
		for (int x = 0; x < 5; x++) begin
			dlt[x] = col[(x + 4) % 5] ^ rotl(col[(x + 1) % 5], 6'd1);
		end
		for (int i = 0; i < 25; i++) begin
			th[i] = lanes[i] ^ dlt[i % 5];
		end
		for (int x = 0; x < 5; x++) begin
			for (int y = 0; y < 5; y++) begin
				pi[y + 5 * ((2 * x + 3 * y) % 5)] = rotl(th[x + 5 * y], RHO[x + 5 * y]);
			end
		end
		for (int y = 0; y < 5; y++) begin
			for (int x = 0; x < 5; x++) begin
				lanes_next[x + 5 * y] = pi[x + 5 * y]
					^ (~pi[(x + 1) % 5 + 5 * y] & pi[(x + 2) % 5 + 5 * y]);
			end
		end
		lanes_next[0] = lanes_next[0] ^ rc;
	end

endmodule

[sv/sha3_224_fixed_message.sv]
`timescale 1ns / 1ps

// SHA3-224 of a message of exactly MESSAGE_BYTES bytes (8 to 136, clamped), sent as
// ceil(MESSAGE_BYTES/8) 64-bit little-endian words; unused bytes of the last word are
// ignored. Words are taken one per cycle while the block is absorbing; a padding step
// follows, one shared Keccak round unit runs 24 times, one round per cycle, and a
// handoff step moves the digest into the output register and clears the state. The
// seven 32-bit digest words leave from that register one per cycle while
// m_axis_tready is high, first byte in bits 7:0, with tlast on the seventh, while the
// next message is already being taken; the handoff waits only if the previous digest
// has not been fully taken.
module sha3_224_fixed_message #(
	parameter int MESSAGE_BYTES = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // message_word[63:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word[31:0]
	output logic        m_axis_tlast
);
	import sha3_224_pkg::*;

	localparam int MsgBytes  = (MESSAGE_BYTES < 8) ? 8 :
		((MESSAGE_BYTES > 136) ? 136 : MESSAGE_BYTES);
	localparam int NWords    = (MsgBytes + 7) / 8;
	localparam int LastBytes = MsgBytes - 8 * (NWords - 1);
	localparam logic [63:0] LastMask = {64{1'b1}} >> (64 - 8 * LastBytes);
	localparam state_t PadBits = (state_t'(PAD_FIRST) << (8 * MsgBytes))
		^ (state_t'(PAD_LAST) << (8 * (8 * PAD_END_LANE + 7)));

	typedef enum logic [3:0] {
		ST_ABSORB  = 4'b0001,
		ST_PAD     = 4'b0010,
		ST_PERMUTE = 4'b0100,
		ST_HANDOFF = 4'b1000
	} fsm_t;

	fsm_t       state_q;
	state_t     lanes_q;
	state_t     lanes_round;
	logic [4:0] words_q;
	logic [4:0] round_q;
	logic [7:0] lfsr_q;
	round_const_t rcon;

	logic [DIGEST_BITS-1:0] digest_q;
	logic                   out_valid_q;
	logic [2:0]             given_q;

	logic in_take;
	logic last_in;
	logic out_take;
	logic out_last;
	logic load;

	assign rcon    = round_const(lfsr_q);
	assign in_take = s_axis_tvalid && s_axis_tready;
	assign last_in = (words_q == 5'(NWords - 1));

	assign out_take = out_valid_q && m_axis_tready;
	assign out_last = (given_q == 3'(DIGEST_WORDS - 1));
	assign load     = (state_q == ST_HANDOFF) && (!out_valid_q || (out_take && out_last));

	assign s_axis_tready = (state_q == ST_ABSORB);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = digest_q[31:0];
	assign m_axis_tlast  = out_last;

	sha3_224_round u_round (
		.lanes      (lanes_q),
		.rc         (rcon.rc),
		.lanes_next (lanes_round)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
			lanes_q <= '0;
			words_q <= '0;
			round_q <= '0;
			lfsr_q  <= LFSR_INIT;
		end else begin
			unique case (state_q)
				ST_ABSORB: begin
					if (in_take) begin
						lanes_q[words_q] <= lanes_q[words_q]
							^ (last_in ? (s_axis_tdata & LastMask) : s_axis_tdata);
						if (last_in) begin
							words_q <= '0;
							state_q <= ST_PAD;
						end else begin
							words_q <= words_q + 5'd1;
						end
					end
				end
				ST_PAD: begin
					lanes_q <= lanes_q ^ PadBits;
					round_q <= '0;
					lfsr_q  <= LFSR_INIT;
					state_q <= ST_PERMUTE;
				end
				ST_PERMUTE: begin
					lanes_q <= lanes_round;
					lfsr_q  <= rcon.lfsr;
					round_q <= round_q + 5'd1;
					if (round_q == 5'(ROUNDS - 1)) begin
						state_q <= ST_HANDOFF;
					end
				end
				ST_HANDOFF: begin
					if (load) begin
						lanes_q <= '0;
						state_q <= ST_ABSORB;
					end
				end
				default: begin
					state_q <= ST_ABSORB;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			given_q     <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			given_q     <= '0;
		end else if (out_take) begin
			if (out_last) begin
				out_valid_q <= 1'b0;
				given_q     <= '0;
			end else begin
				given_q <= given_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digest_q <= DIGEST_BITS'(lanes_q[3:0]);
		end else if (out_take) begin
			digest_q <= digest_q >> 32;
		end
	end

endmodule

[sv/sha3_224_checker.sv]
`timescale 1ns / 1ps
`include "sha3_224_fixed_message_defines.svh"

module sha3_224_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	`SHA3_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "Stalled digest word changed.")
	`SHA3_ASSERT(a_digest_burst, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "Digest words are not contiguous.")
	`SHA3_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(s_axis_tvalid), "Input stalled without taking a word.")
	`SHA3_ASSERT_NEVER(a_last_valid, m_axis_tlast && !m_axis_tvalid, "Last flag without a valid word.")

endmodule

bind sha3_224_fixed_message sha3_224_checker u_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int MSG_BYTES   = 56;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;
	localparam int OUT_WORDS   = 7;
	localparam logic [7:0] PAD_START = 8'h06;
	localparam logic [7:0] PAD_END   = 8'h80;
	localparam logic [7:0] RC_POLY   = 8'h71;
	localparam int RATE_LEN    = 144;

	typedef struct packed {
		logic [31:0] data;
		logic        last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic [63:0]  sponge [25];
	int unsigned  absorbed;
	digest_word_t digest_q [$];
	int           errors;
	int           cycles;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           hold_request;
	int           hold_left;

	sha3_224_fixed_message #(
		.MESSAGE_BYTES(MSG_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned message_len();
		int unsigned n;
		n = MSG_BYTES;
		if (n < 8) n = 8;
		if (n > 136) n = 136;
		return n;
	endfunction

	function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned r);
		int unsigned s;
		s = r % 64;
		if (s == 0) return v;
		return (v << s) | (v >> (64 - s));
	endfunction

	function automatic void sponge_xor_byte(input int unsigned pos, input logic [7:0] val);
		sponge[(pos >> 3) % 25] ^= 64'(val) << ((pos & 7) * 8);
	endfunction

	function automatic void keccak_permute();
		int unsigned rho_step [24] = '{1, 3, 6, 10, 15, 21, 28, 36, 45, 55, 2, 14,
			27, 41, 56, 8, 25, 43, 62, 18, 39, 61, 20, 44};
		logic [63:0] col [5];
		logic [63:0] row [5];
		logic [63:0] d, cur, tmp;
		logic [7:0]  lfsr;
		int unsigned x, y, nx, ny;
		lfsr = 8'h01;
		for (int r = 0; r < 24; r++) begin
			for (int i = 0; i < 5; i++) begin
				col[i] = sponge[i] ^ sponge[i + 5] ^ sponge[i + 10] ^ sponge[i + 15]
					^ sponge[i + 20];
			end
			for (int i = 0; i < 5; i++) begin
				d = col[(i + 4) % 5] ^ rol64(col[(i + 1) % 5], 1);
				for (int j = 0; j < 5; j++) sponge[i + 5 * j] ^= d;
			end
			x = 1;
			y = 0;
			cur = sponge[1];
			for (int t = 0; t < 24; t++) begin
				nx = y;
				ny = (2 * x + 3 * y) % 5;
				x = nx;
				y = ny;
				tmp = sponge[x + 5 * y];
				sponge[x + 5 * y] = rol64(cur, rho_step[t]);
				cur = tmp;
			end
			for (int j = 0; j < 5; j++) begin
				for (int i = 0; i < 5; i++) row[i] = sponge[i + 5 * j];
				for (int i = 0; i < 5; i++) begin
					sponge[i + 5 * j] = row[i] ^ (~row[(i + 1) % 5] & row[(i + 2) % 5]);
				end
			end
			for (int j = 0; j < 7; j++) begin
				if (lfsr[0]) sponge[0][(1 << j) - 1] ^= 1'b1;
				lfsr = lfsr[7] ? ({lfsr[6:0], 1'b0} ^ RC_POLY) : {lfsr[6:0], 1'b0};
			end
		end
	endfunction

	// Absorbs one accepted word; the final word of a message yields the digest words.
	function automatic void absorb_word(input logic [63:0] w);
		int unsigned  nbytes, nwords, left;
		logic [63:0]  masked;
		digest_word_t dw;
		nbytes = message_len();
		nwords = (nbytes + 7) / 8;
		left = nbytes - 8 * absorbed;
		masked = w;
		if (left < 8) masked &= (64'd1 << (8 * left)) - 64'd1;
		sponge[absorbed % 25] ^= masked;
		absorbed = (absorbed + 1) & 31;
		if (absorbed < nwords) return;
		sponge_xor_byte(nbytes, PAD_START);
		sponge_xor_byte(RATE_LEN - 1, PAD_END);
		keccak_permute();
		for (int k = 0; k < OUT_WORDS; k++) begin
			dw.data = 32'(sponge[k >> 1] >> (32 * (k & 1)));
			dw.last = (k == OUT_WORDS - 1);
			digest_q.push_back(dw);
		end
		for (int i = 0; i < 25; i++) sponge[i] = '0;
		absorbed = 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("MISMATCH at cycle %0d: %s: expected %h, got %h", cycles, what, want, got);
		errors++;
	endtask

	task automatic send_word(input logic [63:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		absorb_word(w);
	endtask

	task automatic drain_digests();
		s_axis_tvalid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_message();
		logic [63:0] w;
		for (int i = 0; i < (message_len() + 7) / 8; i++) begin
			case ($urandom_range(15))
				0: w = '0;
				1: w = '1;
				default: w = {$urandom, $urandom};
			endcase
			send_word(w);
		end
	endtask

	task automatic test_fixed_patterns();
		for (int i = 0; i < 7; i++) send_word('0);
		for (int i = 0; i < 7; i++) send_word('1);
		for (int i = 0; i < 7; i++) send_word(i[0] ? 64'h5555_5555_5555_5555
			: 64'hAAAA_AAAA_AAAA_AAAA);
		drain_digests();
	endtask

	task automatic test_random_messages(input int count);
		for (int m = 0; m < count; m++) send_random_message();
		drain_digests();
	endtask

	// The output is held off long enough for the block to fill up and stall its input.
	task automatic test_output_stall();
		hold_request = 300;
		for (int m = 0; m < 4; m++) send_random_message();
		drain_digests();
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", '0, m_axis_tdata);
				end else begin
					if (m_axis_tdata !== digest_q[0].data)
						report_mismatch("digest word", digest_q[0].data, m_axis_tdata);
					if (m_axis_tlast !== digest_q[0].last)
						report_mismatch("last flag", 32'(digest_q[0].last),
							32'(m_axis_tlast));
					void'(digest_q.pop_front());
				end
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		absorbed = 0;
		hold_request = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 25; i++) sponge[i] = '0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 67;
		test_fixed_patterns();
		test_random_messages(9);
		test_output_stall();
		send_idle_pct = 67;
		recv_idle_pct = 37;
		test_random_messages(9);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(4);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (digest_q.size() != 0)
			report_mismatch("digest words never delivered", 32'(digest_q.size()), '0);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/sha3_224_pkg.sv
sv/sha3_224_round.sv
sv/sha3_224_fixed_message.sv
sv/sha3_224_checker.sv
verif/tb.sv
